[rtl/core/ctc_pkg.sv]
// Shared types and character constants for the configuration text cleaner.
package ctc_pkg;

    localparam logic [7:0] C_SEMI      = 8'h3B;
    localparam logic [7:0] C_HASH      = 8'h23;
    localparam logic [7:0] C_SLASH     = 8'h2F;
    localparam logic [7:0] C_STAR      = 8'h2A;
    localparam logic [7:0] C_DQUOTE    = 8'h22;
    localparam logic [7:0] C_SQUOTE    = 8'h27;
    localparam logic [7:0] C_BQUOTE    = 8'h60;
    localparam logic [7:0] C_BACKSLASH = 8'h5C;
    localparam logic [7:0] C_NEWLINE   = 8'h0A;
    localparam logic [7:0] C_TAB       = 8'h09;
    localparam logic [7:0] C_SPACE     = 8'h20;

    localparam int MAX_WORDS = 3;

    typedef enum logic [2:0] {
        MODE_NORMAL = 3'b001,
        MODE_LINE   = 3'b010,
        MODE_BLOCK  = 3'b100
    } t_mode;

    typedef struct packed {
        t_mode      comment_mode;
        logic       slash_pending;
        logic       star_seen;
        logic [7:0] open_quote;
        logic       prev_backslash;
        logic       line_has_text;
        logic       newline_pending;
    } t_state;

    localparam t_state C_STATE_RESET = '{
        comment_mode:    MODE_NORMAL,
        slash_pending:   1'b0,
        star_seen:       1'b0,
        open_quote:      8'h00,
        prev_backslash:  1'b0,
        line_has_text:   1'b0,
        newline_pending: 1'b0
    };

    typedef struct packed {
        logic [7:0] out_byte;
        logic       has_byte;
        logic       out_last;
    } t_result;

    // Words produced by one input byte; cnt holds how many entries are live.
    typedef struct packed {
        logic [1:0]                   cnt;
        t_result [MAX_WORDS-1:0]      res;
    } t_batch;

endpackage

[rtl/core/ctc_in_if.sv]
// Input channel: one text byte per word with an end-of-text flag.
interface ctc_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       in_last;

    modport source (output valid, output in_byte, output in_last, input ready);
    modport sink   (input valid, input in_byte, input in_last, output ready);
endinterface

[rtl/core/ctc_out_if.sv]
// Output channel: one cleaned byte per word with a byte flag and an end flag.
interface ctc_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       has_byte;
    logic       out_last;

    modport source (output valid, output out_byte, output has_byte, output out_last,
                    input ready);
    modport sink   (input valid, input out_byte, input has_byte, input out_last,
                    output ready);
endinterface

[rtl/core/ctc_filter.sv]
// Input register, filter state and the three cleaning filters for one byte.
module ctc_filter (
    input  logic            i_clk,
    input  logic            i_rst_n,
    ctc_in_if.sink          i_in_chan,
    input  logic            i_load_ok,
    output logic            o_batch_valid,
    output ctc_pkg::t_batch o_batch
);

    typedef struct packed {
        ctc_pkg::t_state  st;
        logic [1:0]       cnt;
        logic [2:0][7:0]  bytes;
    } t_work;

    logic            r_in_valid;
    logic [7:0]      r_in_byte;
    logic            r_in_last;
    ctc_pkg::t_state r_state;
    ctc_pkg::t_state n_state;
    ctc_pkg::t_batch w_batch;
    logic            w_fire;

    function automatic t_work f_put(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        if (r.cnt != 2'd3) begin
            r.bytes[r.cnt] = b;
            r.cnt          = r.cnt + 2'd1;
        end
        return r;
    endfunction

    // Blank-line filter: a newline waits until a byte of the next line shows up.
    function automatic t_work f_lines(t_work w, logic [7:0] b);
        t_work r;
        r = w;
        if (b == ctc_pkg::C_NEWLINE) begin
            if (r.st.line_has_text) begin
                r.st.newline_pending = 1'b1;
                r.st.line_has_text   = 1'b0;
            end
        end else begin
            if (r.st.newline_pending) begin
                r = f_put(r, ctc_pkg::C_NEWLINE);
                r.st.newline_pending = 1'b0;
            end
            r = f_put(r, b);
            r.st.line_has_text = 1'b1;
        end
        return r;
    endfunction

    function automatic t_work f_spaces(t_work w, logic [7:0] b);
        t_work r;
        logic  escaped;
        r       = w;
        escaped = r.st.prev_backslash;
        r.st.prev_backslash = (b == ctc_pkg::C_BACKSLASH);
        if (b == ctc_pkg::C_DQUOTE || b == ctc_pkg::C_SQUOTE || b == ctc_pkg::C_BQUOTE) begin
            if (!escaped) begin
                r.st.open_quote = (r.st.open_quote != 8'h00) ? 8'h00 : b;
            end
            r = f_lines(r, b);
        end else if (b == ctc_pkg::C_SPACE) begin
            if (r.st.open_quote != 8'h00) begin
                r = f_lines(r, b);
            end
        end else if (b == ctc_pkg::C_TAB || b == ctc_pkg::C_NEWLINE) begin
            r = f_lines(r, b);
        end else if (b > ctc_pkg::C_SPACE) begin
            r = f_lines(r, b);
        end
        return r;
    endfunction

    function automatic t_work f_comments(t_work w, logic [7:0] b);
        t_work r;
        logic  done;
        r    = w;
        done = 1'b0;
        case (r.st.comment_mode)
            ctc_pkg::MODE_LINE: begin
                if (b == ctc_pkg::C_NEWLINE) begin
                    r.st.comment_mode = ctc_pkg::MODE_NORMAL;
                    r = f_spaces(r, b);
                end
            end
            ctc_pkg::MODE_BLOCK: begin
                if (r.st.star_seen && b == ctc_pkg::C_SLASH) begin
                    r.st.comment_mode = ctc_pkg::MODE_NORMAL;
                    r.st.star_seen    = 1'b0;
                end else begin
                    r.st.star_seen = (b == ctc_pkg::C_STAR);
                end
            end
            default: begin
                if (r.st.slash_pending) begin
                    r.st.slash_pending = 1'b0;
                    if (b == ctc_pkg::C_STAR) begin
                        r.st.comment_mode = ctc_pkg::MODE_BLOCK;
                        r.st.star_seen    = 1'b0;
                        done              = 1'b1;
                    end else begin
                        r = f_spaces(r, ctc_pkg::C_SLASH);
                    end
                end
                if (!done) begin
                    if (b == ctc_pkg::C_SEMI || b == ctc_pkg::C_HASH) begin
                        r.st.comment_mode = ctc_pkg::MODE_LINE;
                    end else if (b == ctc_pkg::C_SLASH) begin
                        r.st.slash_pending = 1'b1;
                    end else begin
                        r = f_spaces(r, b);
                    end
                end
            end
        endcase
        return r;
    endfunction

    always_comb begin
        t_work w;
        w.st    = r_state;
        w.cnt   = 2'd0;
        w.bytes = '0;
        w = f_comments(w, r_in_byte);
        if (r_in_last && w.st.slash_pending) begin
            w.st.slash_pending = 1'b0;
            w = f_spaces(w, ctc_pkg::C_SLASH);
        end
        for (int i = 0; i < ctc_pkg::MAX_WORDS; i++) begin
            w_batch.res[i].has_byte = (2'(i) < w.cnt);
            w_batch.res[i].out_byte = (2'(i) < w.cnt) ? w.bytes[i] : 8'h00;
            w_batch.res[i].out_last = r_in_last && (2'(i) == w.cnt - 2'd1);
        end
        w_batch.cnt = w.cnt;
        // End of text with nothing to say still produces a bare end marker.
        if (r_in_last && w.cnt == 2'd0) begin
            w_batch.cnt    = 2'd1;
            w_batch.res[0] = '{out_byte: 8'h00, has_byte: 1'b0, out_last: 1'b1};
        end
        n_state = r_in_last ? ctc_pkg::C_STATE_RESET : w.st;
    end

    assign w_fire          = r_in_valid && i_load_ok;
    assign i_in_chan.ready = !r_in_valid || i_load_ok;
    assign o_batch_valid   = r_in_valid;
    assign o_batch         = w_batch;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_state    <= ctc_pkg::C_STATE_RESET;
        end else begin
            if (i_in_chan.valid && i_in_chan.ready) begin
                r_in_valid <= 1'b1;
            end else if (w_fire) begin
                r_in_valid <= 1'b0;
            end
            if (w_fire) begin
                r_state <= n_state;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_in_chan.valid && i_in_chan.ready) begin
            r_in_byte <= i_in_chan.in_byte;
            r_in_last <= i_in_chan.in_last;
        end
    end

endmodule

[rtl/core/ctc_outbuf.sv]
// Result buffer that holds the words of one input byte and hands them out in order.
module ctc_outbuf (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_batch_valid,
    input  ctc_pkg::t_batch i_batch,
    output logic            o_load_ok,
    ctc_out_if.source       o_out_chan
);

    ctc_pkg::t_result [ctc_pkg::MAX_WORDS-1:0] r_res;
    logic [1:0] r_cnt;
    logic [1:0] r_head;
    logic       w_out_fire;
    logic       w_load;

    assign w_out_fire = o_out_chan.valid && o_out_chan.ready;
    // A new batch may land when the buffer is empty or when the last held word leaves in this cycle.
    assign o_load_ok  = (r_cnt == 2'd0) || (r_cnt == 2'd1 && o_out_chan.ready);
    assign w_load     = i_batch_valid && o_load_ok;

    assign o_out_chan.valid    = (r_cnt != 2'd0);
    assign o_out_chan.out_byte = r_res[r_head].out_byte;
    assign o_out_chan.has_byte = r_res[r_head].has_byte;
    assign o_out_chan.out_last = r_res[r_head].out_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cnt  <= 2'd0;
            r_head <= 2'd0;
        end else if (w_load) begin
            r_cnt  <= i_batch.cnt;
            r_head <= 2'd0;
        end else if (w_out_fire) begin
            r_cnt  <= r_cnt - 2'd1;
            r_head <= r_head + 2'd1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_load) begin
            r_res <= i_batch.res;
        end
    end

endmodule

[rtl/core/config_text_cleaner_top.sv]
// Top level of the configuration text cleaner.
//
// Usage: text bytes enter on i_in_chan, one byte per word, with in_last set on
// the final byte of a text. Comments, spaces outside quotes, bytes below space
// other than tab and newline, and blank lines are removed; cleaned bytes leave
// on o_out_chan, one per word. A word with has_byte low carries no byte; it
// appears only as the end marker of a text that ends without producing a byte.
// out_last marks the final word of each text, after which all filter state is
// back at its reset values. An accepted byte is filtered from the input
// register, and its words are registered in the result buffer, from which the
// output channel offers them. Throughput is one byte per cycle while each byte
// yields at most one word and the receiver does not stall; a byte that yields
// more words (up to 3) holds the output until the single output port has
// drained them from the result buffer. Bytes that yield nothing still pass at
// one per cycle while the result buffer is free to load.
// Reset (i_rst_n low, synchronous) empties the input register and the buffer
// and returns all filters to normal text. When the receiver stalls, the buffer
// holds its words, then the input register fills and i_in_chan.ready drops.
module config_text_cleaner_top (
    input  logic      i_clk,
    input  logic      i_rst_n,
    ctc_in_if.sink    i_in_chan,
    ctc_out_if.source o_out_chan
);

    logic            w_load_ok;
    logic            w_batch_valid;
    ctc_pkg::t_batch w_batch;

    ctc_filter u_filter (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_in_chan     (i_in_chan),
        .i_load_ok     (w_load_ok),
        .o_batch_valid (w_batch_valid),
        .o_batch       (w_batch)
    );

    ctc_outbuf u_outbuf (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_batch_valid (w_batch_valid),
        .i_batch       (w_batch),
        .o_load_ok     (w_load_ok),
        .o_out_chan    (o_out_chan)
    );

`ifndef SYNTH
    a_empty_word_is_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_chan.valid && !o_out_chan.has_byte) |-> o_out_chan.out_last)
        else $error("word without a byte is not the end of a text");

    a_empty_word_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_out_chan.valid && !o_out_chan.has_byte) |-> (o_out_chan.out_byte == 8'h00))
        else $error("word without a byte carries a nonzero byte");

    a_idle_buffer_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !o_out_chan.valid |-> w_load_ok)
        else $error("empty result buffer refuses a batch");

    a_last_batch_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_batch_valid && w_batch.cnt == 2'd0) |-> !w_batch.res[0].out_last)
        else $error("end of text produced no word");
`endif

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the configuration text cleaner: directed and random texts.
module testbench;
    import ctc_pkg::*;

    localparam int TEXT_BYTES  = 330;
    localparam int LONG_STALL  = 120;
    localparam int SETTLE_WAIT = 20;

    // Predicts the cleaned words of each accepted byte and checks the words that leave.
    class cleaned_text_sb;
        t_mode      mode;
        bit         slash_held;
        bit         star_prev;
        logic [7:0] quote_char;
        bit         after_backslash;
        bit         line_busy;
        bit         nl_held;
        t_result    step_words[$];
        t_result    expected_words[$];
        int         errors;
        int         words_checked;
        int         texts_done;

        function new();
            errors = 0;
            words_checked = 0;
            texts_done = 0;
            clear_state();
        endfunction

        function void clear_state();
            mode = MODE_NORMAL;
            slash_held = 1'b0;
            star_prev = 1'b0;
            quote_char = 8'h00;
            after_backslash = 1'b0;
            line_busy = 1'b0;
            nl_held = 1'b0;
        endfunction

        function int pending();
            return expected_words.size();
        endfunction

        function void emit(logic [7:0] b);
            t_result w;
            if (step_words.size() < MAX_WORDS) begin
                w.out_byte = b;
                w.has_byte = 1'b1;
                w.out_last = 1'b0;
                step_words.push_back(w);
            end
        endfunction

        // A newline is held until a byte follows it, so blank lines vanish.
        function void keep_line(logic [7:0] b);
            if (b == C_NEWLINE) begin
                if (line_busy) begin
                    nl_held = 1'b1;
                    line_busy = 1'b0;
                end
                return;
            end
            if (nl_held) begin
                emit(C_NEWLINE);
                nl_held = 1'b0;
            end
            emit(b);
            line_busy = 1'b1;
        endfunction

        function void squeeze_spaces(logic [7:0] b);
            bit escaped;
            escaped = after_backslash;
            after_backslash = (b == C_BACKSLASH);
            if (b == C_DQUOTE || b == C_SQUOTE || b == C_BQUOTE) begin
                if (!escaped)
                    quote_char = (quote_char != 8'h00) ? 8'h00 : b;
                keep_line(b);
            end else if (b == C_SPACE) begin
                if (quote_char != 8'h00)
                    keep_line(b);
            end else if (b == C_TAB || b == C_NEWLINE || b > C_SPACE) begin
                keep_line(b);
            end
        endfunction

        function void strip_comments(logic [7:0] b);
            if (mode == MODE_LINE) begin
                if (b == C_NEWLINE) begin
                    mode = MODE_NORMAL;
                    squeeze_spaces(b);
                end
                return;
            end
            if (mode == MODE_BLOCK) begin
                if (star_prev && b == C_SLASH) begin
                    mode = MODE_NORMAL;
                    star_prev = 1'b0;
                end else begin
                    star_prev = (b == C_STAR);
                end
                return;
            end
            if (slash_held) begin
                slash_held = 1'b0;
                if (b == C_STAR) begin
                    mode = MODE_BLOCK;
                    star_prev = 1'b0;
                    return;
                end
                squeeze_spaces(C_SLASH);
            end
            if (b == C_SEMI || b == C_HASH)
                mode = MODE_LINE;
            else if (b == C_SLASH)
                slash_held = 1'b1;
            else
                squeeze_spaces(b);
        endfunction

        function void note_byte(logic [7:0] b, bit last);
            t_result marker;
            step_words.delete();
            strip_comments(b);
            if (last) begin
                if (slash_held) begin
                    slash_held = 1'b0;
                    squeeze_spaces(C_SLASH);
                end
                nl_held = 1'b0;
                if (step_words.size() == 0) begin
                    marker.out_byte = 8'h00;
                    marker.has_byte = 1'b0;
                    marker.out_last = 1'b1;
                    step_words.push_back(marker);
                end else begin
                    step_words[step_words.size()-1].out_last = 1'b1;
                end
                clear_state();
                texts_done++;
            end
            foreach (step_words[i])
                expected_words.push_back(step_words[i]);
        endfunction

        task report_mismatch(string msg);
            errors++;
            if (errors <= 30)
                $display("mismatch at %0t: %s", $realtime, msg);
        endtask

        task check_word(t_result got);
            t_result want;
            if (expected_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word byte=%02h has=%0b last=%0b",
                                          got.out_byte, got.has_byte, got.out_last));
                return;
            end
            want = expected_words.pop_front();
            words_checked++;
            if (got.out_byte !== want.out_byte)
                report_mismatch($sformatf("out_byte %02h, expected %02h",
                                          got.out_byte, want.out_byte));
            if (got.has_byte !== want.has_byte)
                report_mismatch($sformatf("has_byte %0b, expected %0b",
                                          got.has_byte, want.has_byte));
            if (got.out_last !== want.out_last)
                report_mismatch($sformatf("out_last %0b, expected %0b",
                                          got.out_last, want.out_last));
        endtask
    endclass

    logic i_clk;
    logic i_rst_n;

    ctc_in_if  in_chan();
    ctc_out_if out_chan();

    config_text_cleaner_top dut (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_chan  (in_chan),
        .o_out_chan (out_chan)
    );

    cleaned_text_sb sb = new();
    int  bytes_sent = 0;
    bit  steady = 1'b0;
    bit  stall_req = 1'b0;
    int  long_stalls = 0;
    int  drains = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #3_000_000;
        $display("TB_ERROR");
        $finish;
    end

    // Mostly no gap, often a short one, now and then a long one.
    function automatic int pick_gap();
        int r;
        r = $urandom_range(0, 99);
        if (steady || r < 60)
            return 0;
        if (r < 92)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    // Byte mix weighted toward the characters that steer the filters.
    function automatic logic [7:0] pick_text_byte();
        int r;
        r = $urandom_range(0, 99);
        if (r < 26) return 8'($urandom_range(8'h61, 8'h7A));
        if (r < 34) return C_SPACE;
        if (r < 43) return C_NEWLINE;
        if (r < 47) return C_SEMI;
        if (r < 50) return C_HASH;
        if (r < 58) return C_SLASH;
        if (r < 65) return C_STAR;
        if (r < 69) return C_DQUOTE;
        if (r < 72) return C_SQUOTE;
        if (r < 75) return C_BQUOTE;
        if (r < 79) return C_BACKSLASH;
        if (r < 82) return C_TAB;
        if (r < 86) return 8'($urandom_range(1, 31));
        return 8'($urandom_range(1, 255));
    endfunction

    task send_word(logic [7:0] b, bit last);
        int gap;
        in_chan.valid   <= 1'b1;
        in_chan.in_byte <= b;
        in_chan.in_last <= last;
        do @(posedge i_clk); while (in_chan.ready !== 1'b1);
        sb.note_byte(b, last);
        bytes_sent++;
        gap = pick_gap();
        if (gap > 0) begin
            in_chan.valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task send_text(string s, bit end_text);
        for (int i = 0; i < s.len(); i++)
            send_word(s[i], end_text && i == s.len() - 1);
    endtask

    // The sender goes idle so that the last byte is not offered a second time.
    task wait_drained();
        in_chan.valid <= 1'b0;
        do @(posedge i_clk); while (sb.pending() > 0);
        drains++;
    endtask

    // Receiver: random back-pressure, plus one long hold on request.
    initial begin : receiver
        int stall_left;
        stall_left = 0;
        out_chan.ready <= 1'b0;
        wait (i_rst_n === 1'b1);
        forever begin
            @(posedge i_clk);
            if (stall_req) begin
                out_chan.ready <= 1'b0;
                stall_req = 1'b0;
                repeat (LONG_STALL) @(posedge i_clk);
                long_stalls++;
            end else if (stall_left > 0) begin
                out_chan.ready <= 1'b0;
                stall_left--;
            end else begin
                out_chan.ready <= 1'b1;
                stall_left = pick_gap();
            end
        end
    end

    always @(posedge i_clk) begin : monitor
        t_result w;
        if (i_rst_n === 1'b1 && out_chan.valid === 1'b1 && out_chan.ready === 1'b1) begin
            w.out_byte = out_chan.out_byte;
            w.has_byte = out_chan.has_byte;
            w.out_last = out_chan.out_last;
            sb.check_word(w);
        end
    end

    initial begin : stimulus
        int text_idx;
        int len;
        in_chan.valid   <= 1'b0;
        in_chan.in_byte <= 8'h00;
        in_chan.in_last <= 1'b0;
        i_rst_n <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // A lone slash is released when the text ends.
        send_text("/", 1'b1);
        // Held newline, released slash and the byte itself leave together.
        send_text("a\n/b", 1'b1);
        // A text that ends inside a line comment yields only the end marker.
        send_text(";c", 1'b1);
        // Block comment, escaped quote inside a quote, kept and dropped spaces.
        send_text("x/**/ \"\\\" y\"'", 1'b0);
        // A quote opened by an apostrophe is closed by a backquote.
        send_word(C_BQUOTE, 1'b0);
        send_word(8'h01, 1'b0);
        send_word(C_TAB, 1'b0);
        send_word(8'hFF, 1'b0);
        send_text("\n\n #y\n", 1'b0);
        // Unclosed block comment swallows the rest; the held newline is dropped.
        send_text("/*z", 1'b1);
        wait_drained();

        text_idx = 0;
        while (bytes_sent < TEXT_BYTES) begin
            steady = (text_idx >= 4 && text_idx < 9) || (text_idx >= 20 && text_idx < 24);
            if (text_idx == 4)
                stall_req = 1'b1;
            if (text_idx == 14)
                wait_drained();
            len = ($urandom_range(0, 9) == 0) ? 1 : $urandom_range(2, 24);
            for (int i = 0; i < len; i++)
                send_word(pick_text_byte(), i == len - 1);
            text_idx++;
        end
        steady = 1'b0;

        wait_drained();
        repeat (SETTLE_WAIT) @(posedge i_clk);

        $display("Covered %0d bytes in %0d texts with %0d words checked.",
                 bytes_sent, sb.texts_done, sb.words_checked);
        $display("Included %0d long receiver hold(s) and %0d full drain pause(s).",
                 long_stalls, drains);
        if (sb.errors == 0) begin
            $display("TB_OK");
        end else begin
            $display("TB_ERROR");
        end
        $finish;
    end

endmodule
